FILE: rtl/extent_block_map_allocator_top_assert.svh
// Assertion macros for the extent block map allocator
`ifndef EXTENT_BLOCK_MAP_ALLOCATOR_TOP_ASSERT_SVH
`define EXTENT_BLOCK_MAP_ALLOCATOR_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define EBMA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define EBMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ebma_pkg.sv
// Package: shared types, codes and defaults of the extent block map allocator
`timescale 1ns / 1ps
package ebma_pkg;

    localparam int BLOCKS_DEF      = 4096;
    localparam int MAX_EXTENTS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int FB_W     = 32;
    localparam int PB_W     = 12;
    localparam int CNT_W    = 13;
    localparam int EIDX_W   = 4;
    localparam int ACC_W    = 33;
    localparam int CFG_W    = 13;

    localparam logic [1:0] CMD_MAP_READ  = 2'd0;
    localparam logic [1:0] CMD_MAP_WRITE = 2'd1;
    localparam logic [1:0] CMD_ALLOC_RUN = 2'd2;
    localparam logic [1:0] CMD_FREE_RUN  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    localparam logic [1:0] GR_EXISTING = 2'd0;
    localparam logic [1:0] GR_EXTENDED = 2'd1;
    localparam logic [1:0] GR_NEW      = 2'd2;

    localparam logic CFG_ALLOC_BASE  = 1'b0;
    localparam logic CFG_DISK_BLOCKS = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [FB_W-1:0]  logical_block;
        logic [PB_W-1:0]  run_start;
        logic [CNT_W-1:0] run_count;
        logic             count_zero;
    } ebma_item_t;

    typedef struct packed {
        logic       valid;
        ebma_item_t item;
    } ebma_queue_t;

endpackage

FILE: rtl/ebma_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module ebma_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

FILE: rtl/ebma_front.sv
// Front end: accepts items, classifies them and queues them for the back end
`timescale 1ns / 1ps
module ebma_front
    import ebma_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CMD_W-1:0] command,
    input  logic [FB_W-1:0]  logical_block,
    input  logic [PB_W-1:0]  run_start,
    input  logic [CNT_W-1:0] run_count,
    input  logic             back_clearing,
    input  logic             q_pop,
    output ebma_queue_t      q_head
);

    ebma_item_t  q_mem_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;
    ebma_item_t  new_item;

    assign in_stall = (count_reg == 2'd2) || back_clearing;
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && (count_reg != 2'd0);

    always_comb
    begin
        new_item.command       = command;
        new_item.logical_block = logical_block;
        new_item.run_start     = run_start;
        new_item.run_count     = run_count;
        new_item.count_zero    = (run_count == '0);
    end

    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wptr_reg] <= new_item;
        end
    end

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = q_mem_reg[rptr_reg];

endmodule

FILE: rtl/ebma_back.sv
// Back end: extent walk, bitmap allocation and release, result register
`timescale 1ns / 1ps
`include "extent_block_map_allocator_top_assert.svh"
module ebma_back
    import ebma_pkg::*;
#(
    parameter int BLOCKS      = BLOCKS_DEF,
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ebma_queue_t       q_head,
    output logic              q_pop,
    output logic              back_clearing,
    input  logic [PB_W-1:0]   alloc_base,
    input  logic [CNT_W-1:0]  disk_blocks,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [PB_W-1:0]   mapped_block,
    output logic [EIDX_W-1:0] extent_index,
    output logic [1:0]        growth,
    output logic [CNT_W-1:0]  free_count
);

    localparam int AW = $clog2(BLOCKS);
    localparam int CW = (AW + 2 > 15) ? AW + 2 : 15;
    localparam int FW = AW + 1;
    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int UW = $clog2(MAX_EXTENTS + 1);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_WALK    = 4'd2;
    localparam logic [3:0] S_GROW_RD = 4'd3;
    localparam logic [3:0] S_GROW_CK = 4'd4;
    localparam logic [3:0] S_FF_TEST = 4'd5;
    localparam logic [3:0] S_FF_RD   = 4'd6;
    localparam logic [3:0] S_FF_CK   = 4'd7;
    localparam logic [3:0] S_FF_MARK = 4'd8;
    localparam logic [3:0] S_FR_TEST = 4'd9;
    localparam logic [3:0] S_FR_RD   = 4'd10;
    localparam logic [3:0] S_FR_CK   = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0]        state_reg, state_next;
    ebma_item_t        item_reg, item_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [FW-1:0]     free_reg, free_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [UW-1:0]     wi_reg, wi_next;
    logic [CW-1:0]     blk_reg, blk_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     ffcnt_reg, ffcnt_next;
    logic              ffnew_reg, ffnew_next;
    logic [1:0]        rst_st_reg, rst_st_next;
    logic [PB_W-1:0]   rphys_reg, rphys_next;
    logic [EIDX_W-1:0] ridx_reg, ridx_next;
    logic [1:0]        rgr_reg, rgr_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        o_status_reg;
    logic [PB_W-1:0]   o_phys_reg;
    logic [EIDX_W-1:0] o_idx_reg;
    logic [1:0]        o_gr_reg;
    logic [CNT_W-1:0]  o_free_reg;

    logic [PB_W-1:0]   ext_first_reg [MAX_EXTENTS];
    logic [CNT_W-1:0]  ext_len_reg [MAX_EXTENTS];

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic              ram_wdata;
    logic              ram_rdata;

    logic [CW-1:0]     disk_end;
    logic [IW-1:0]     last_idx;
    logic [IW-1:0]     sel_idx;
    logic [PB_W-1:0]   sel_first;
    logic [CNT_W-1:0]  sel_len;
    logic [ACC_W-1:0]  acc_sum;
    logic [CW-1:0]     next_blk;
    logic [CW-1:0]     ff_addr;
    logic [CW-1:0]     fr_addr;
    logic              load_out;
    logic              ext_we_grow;
    logic              ext_we_new;
    logic [FW-1:0]     free_dec;

    assign disk_end = (CW'(disk_blocks) < CW'(BLOCKS)) ? CW'(disk_blocks) : CW'(BLOCKS);
    assign last_idx = IW'(used_reg - UW'(1));
    assign sel_idx  = (wi_reg < used_reg) ? IW'(wi_reg) : last_idx;
    assign sel_first = ext_first_reg[sel_idx];
    assign sel_len   = ext_len_reg[sel_idx];
    assign acc_sum   = acc_reg + ACC_W'(sel_len);
    assign next_blk  = CW'(sel_first) + CW'(sel_len);
    assign ff_addr   = blk_reg + i_reg;
    assign fr_addr   = CW'(item_reg.run_start) + i_reg;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign free_dec  = (free_reg != '0) ? free_reg - FW'(1) : free_reg;

    assign back_clearing = (state_reg == S_CLEAR);

    ebma_ram #(
        .WIDTH (1),
        .DEPTH (BLOCKS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        used_next   = used_reg;
        free_next   = free_reg;
        acc_next    = acc_reg;
        wi_next     = wi_reg;
        blk_next    = blk_reg;
        i_next      = i_reg;
        ffcnt_next  = ffcnt_reg;
        ffnew_next  = ffnew_reg;
        rst_st_next = rst_st_reg;
        rphys_next  = rphys_reg;
        ridx_next   = ridx_reg;
        rgr_next    = rgr_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = AW'(blk_reg);
        ram_wdata   = 1'b0;
        ext_we_grow = 1'b0;
        ext_we_new  = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = AW'(blk_reg);
                ram_wdata = 1'b0;
                blk_next  = blk_reg + CW'(1);
                if (blk_reg == CW'(BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop       = 1'b1;
                    item_next   = q_head.item;
                    acc_next    = '0;
                    wi_next     = '0;
                    i_next      = '0;
                    rst_st_next = ST_OK;
                    rphys_next  = '0;
                    ridx_next   = '0;
                    rgr_next    = GR_EXISTING;
                    ffnew_next  = 1'b0;
                    case (q_head.item.command)
                        CMD_MAP_READ, CMD_MAP_WRITE:
                        begin
                            state_next = S_WALK;
                        end
                        CMD_ALLOC_RUN:
                        begin
                            if (q_head.item.count_zero)
                            begin
                                rst_st_next = ST_NO_SPACE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                blk_next   = CW'(alloc_base);
                                ffcnt_next = CW'(q_head.item.run_count);
                                state_next = S_FF_TEST;
                            end
                        end
                        default:
                        begin
                            state_next = S_FR_TEST;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (wi_reg < used_reg)
                begin
                    if (ACC_W'(item_reg.logical_block) < acc_sum)
                    begin
                        rphys_next = PB_W'(sel_first +
                                     PB_W'(ACC_W'(item_reg.logical_block) - acc_reg));
                        ridx_next  = EIDX_W'(wi_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                        wi_next  = wi_reg + UW'(1);
                    end
                end
                else if (item_reg.command == CMD_MAP_READ)
                begin
                    rst_st_next = ST_UNMAPPED;
                    state_next  = S_DONE;
                end
                else if ((used_reg != '0) && (ACC_W'(item_reg.logical_block) == acc_reg)
                         && (next_blk < disk_end))
                begin
                    blk_next   = next_blk;
                    state_next = S_GROW_RD;
                end
                else if (used_reg >= UW'(MAX_EXTENTS))
                begin
                    rst_st_next = ST_NO_SPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    ffnew_next = 1'b1;
                    blk_next   = CW'(alloc_base);
                    ffcnt_next = CW'(1);
                    i_next     = '0;
                    state_next = S_FF_TEST;
                end
            end
            S_GROW_RD:
            begin
                ram_addr   = AW'(blk_reg);
                state_next = S_GROW_CK;
            end
            S_GROW_CK:
            begin
                ram_addr = AW'(blk_reg);
                if (!ram_rdata)
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = 1'b1;
                    free_next   = free_dec;
                    ext_we_grow = 1'b1;
                    rphys_next  = PB_W'(blk_reg);
                    ridx_next   = EIDX_W'(last_idx);
                    rgr_next    = GR_EXTENDED;
                    state_next  = S_DONE;
                end
                else if (used_reg >= UW'(MAX_EXTENTS))
                begin
                    rst_st_next = ST_NO_SPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    ffnew_next = 1'b1;
                    blk_next   = CW'(alloc_base);
                    ffcnt_next = CW'(1);
                    i_next     = '0;
                    state_next = S_FF_TEST;
                end
            end
            S_FF_TEST:
            begin
                if (i_reg == ffcnt_reg)
                begin
                    i_next     = '0;
                    state_next = S_FF_MARK;
                end
                else if ((i_reg == '0) &&
                         !((blk_reg < disk_end) && (ffcnt_reg <= disk_end - blk_reg)))
                begin
                    rst_st_next = ST_NO_SPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_FF_RD;
                end
            end
            S_FF_RD:
            begin
                ram_addr   = AW'(ff_addr);
                state_next = S_FF_CK;
            end
            S_FF_CK:
            begin
                if (ram_rdata)
                begin
                    blk_next = ff_addr + CW'(1);
                    i_next   = '0;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
                state_next = S_FF_TEST;
            end
            S_FF_MARK:
            begin
                ram_we    = 1'b1;
                ram_addr  = AW'(ff_addr);
                ram_wdata = 1'b1;
                free_next = free_dec;
                i_next    = i_reg + CW'(1);
                if (i_reg == ffcnt_reg - CW'(1))
                begin
                    rphys_next = PB_W'(blk_reg);
                    if (ffnew_reg)
                    begin
                        ext_we_new = 1'b1;
                        used_next  = used_reg + UW'(1);
                        ridx_next  = EIDX_W'(used_reg);
                        rgr_next   = GR_NEW;
                    end
                    state_next = S_DONE;
                end
            end
            S_FR_TEST:
            begin
                if (i_reg == CW'(item_reg.run_count))
                begin
                    state_next = S_DONE;
                end
                else if (fr_addr >= disk_end)
                begin
                    rst_st_next = ST_BAD_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_FR_RD;
                end
            end
            S_FR_RD:
            begin
                ram_addr   = AW'(fr_addr);
                state_next = S_FR_CK;
            end
            S_FR_CK:
            begin
                ram_addr = AW'(fr_addr);
                if (!ram_rdata)
                begin
                    rst_st_next = ST_BAD_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = 1'b0;
                    if (free_reg < FW'(BLOCKS))
                    begin
                        free_next = free_reg + FW'(1);
                    end
                    i_next     = i_reg + CW'(1);
                    state_next = S_FR_TEST;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            used_reg      <= '0;
            free_reg      <= FW'(BLOCKS);
            blk_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            blk_reg       <= blk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        acc_reg    <= acc_next;
        wi_reg     <= wi_next;
        i_reg      <= i_next;
        ffcnt_reg  <= ffcnt_next;
        ffnew_reg  <= ffnew_next;
        rst_st_reg <= rst_st_next;
        rphys_reg  <= rphys_next;
        ridx_reg   <= ridx_next;
        rgr_reg    <= rgr_next;
        if (ext_we_grow)
        begin
            ext_len_reg[last_idx] <= sel_len + CNT_W'(1);
        end
        if (ext_we_new)
        begin
            ext_first_reg[IW'(used_reg)] <= PB_W'(blk_reg);
            ext_len_reg[IW'(used_reg)]   <= CNT_W'(1);
        end
        if (load_out)
        begin
            o_status_reg <= rst_st_reg;
            o_phys_reg   <= rphys_reg;
            o_idx_reg    <= ridx_reg;
            o_gr_reg     <= rgr_reg;
            o_free_reg   <= CNT_W'(free_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign mapped_block = o_phys_reg;
    assign extent_index = o_idx_reg;
    assign growth       = o_gr_reg;
    assign free_count   = o_free_reg;

    `EBMA_ASSERT_ALWAYS(a_used_bound, used_reg <= UW'(MAX_EXTENTS), "extent count overflow")
    `EBMA_ASSERT_ALWAYS(a_free_bound, free_reg <= FW'(BLOCKS), "free count overflow")
    `EBMA_ASSERT_NEXT(a_result_shown, load_out, out_valid_reg && state_reg == S_IDLE, "result lost")

endmodule

FILE: rtl/extent_block_map_allocator_top.sv
// Top level: configuration registers, front end queue and back end
`timescale 1ns / 1ps
// After reset the block clears the whole free-block bitmap and holds in_stall high;
// configuration writes are taken throughout. Items then run one at a time in the back
// end: a map command walks one extent per cycle, growing an extent reads and checks the
// next block, a first-fit search tests, reads and checks every bitmap block it examines
// and then marks each block of the run, and free_run tests, reads and checks every block
// before it releases it, as the bitmap sits in a single-port RAM with registered read.
// Up to two items queue ahead of the back end. A finished result waits in the output
// register; meanwhile the back end carries on with the next item, but cannot hand its
// result over until the waiting one has been taken.
module extent_block_map_allocator_top
    import ebma_pkg::*;
#(
    parameter int BLOCKS      = BLOCKS_DEF,
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [FB_W-1:0]   logical_block,
    input  logic [PB_W-1:0]   run_start,
    input  logic [CNT_W-1:0]  run_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [PB_W-1:0]   mapped_block,
    output logic [EIDX_W-1:0] extent_index,
    output logic [1:0]        growth,
    output logic [CNT_W-1:0]  free_count
);

    logic [PB_W-1:0]  alloc_base_reg;
    logic [CNT_W-1:0] disk_blocks_reg;
    ebma_queue_t      q_head;
    logic             q_pop;
    logic             back_clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_base_reg  <= PB_W'(1);
            disk_blocks_reg <= CNT_W'(4096);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALLOC_BASE:  alloc_base_reg  <= PB_W'(cfg_data);
                CFG_DISK_BLOCKS: disk_blocks_reg <= cfg_data;
                default:         alloc_base_reg  <= alloc_base_reg;
            endcase
        end
    end

    ebma_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .logical_block (logical_block),
        .run_start     (run_start),
        .run_count     (run_count),
        .back_clearing (back_clearing),
        .q_pop         (q_pop),
        .q_head        (q_head)
    );

    ebma_back #(
        .BLOCKS      (BLOCKS),
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .back_clearing (back_clearing),
        .alloc_base    (alloc_base_reg),
        .disk_blocks   (disk_blocks_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .mapped_block  (mapped_block),
        .extent_index  (extent_index),
        .growth        (growth),
        .free_count    (free_count)
    );

endmodule

FILE: tb/tb.sv
// Testbench for the extent block map allocator: directed and random items checked against a predictor
`timescale 1ns / 1ps
module tb;
    import ebma_pkg::*;

    typedef struct {
        logic [1:0]       status;
        logic [PB_W-1:0]  phys;
        logic [EIDX_W-1:0] idx;
        logic [1:0]       growth;
        logic [CNT_W-1:0] free;
    } map_result_t;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } run_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [CMD_W-1:0]  command;
    logic [FB_W-1:0]   logical_block;
    logic [PB_W-1:0]   run_start;
    logic [CNT_W-1:0]  run_count;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [PB_W-1:0]   mapped_block;
    logic [EIDX_W-1:0] extent_index;
    logic [1:0]        growth;
    logic [CNT_W-1:0]  free_count;

    // predictor state
    bit          used_map [BLOCKS_DEF];
    int unsigned ext_first [MAX_EXTENTS_DEF];
    int unsigned ext_len [MAX_EXTENTS_DEF];
    int unsigned ext_cnt;
    int unsigned free_tot;
    int unsigned alloc_base_cfg;
    int unsigned total_cfg;

    map_result_t pending_results[$];
    run_t        allocated_runs[$];
    int          errors;
    bit          no_gaps;
    int          hold_len;

    extent_block_map_allocator_top dut (.*);

    always #5 clk = ~clk;

    function automatic int unsigned disk_lim();
        return (total_cfg < BLOCKS_DEF) ? total_cfg : BLOCKS_DEF;
    endfunction

    function automatic bit blk_taken(int unsigned b);
        if (b >= disk_lim())
            return 1'b1;
        return used_map[b];
    endfunction

    function automatic void take_blk(int unsigned b);
        used_map[b] = 1'b1;
        if (free_tot > 0)
            free_tot--;
    endfunction

    function automatic bit fit_run(int unsigned cnt, output int unsigned st);
        int unsigned e;
        int unsigned b;
        int unsigned i;
        bit ok;
        e = disk_lim();
        b = alloc_base_cfg;
        st = 0;
        if (cnt == 0)
            return 1'b0;
        while (b < e && cnt <= e - b) begin
            ok = 1'b1;
            for (i = 0; i < cnt; i++) begin
                if (blk_taken(b + i)) begin
                    ok = 1'b0;
                    b += i + 1;
                    break;
                end
            end
            if (ok) begin
                for (i = 0; i < cnt; i++)
                    take_blk(b + i);
                st = b;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic longint unsigned mapped_blocks();
        longint unsigned acc;
        acc = 0;
        for (int i = 0; i < ext_cnt; i++)
            acc += ext_len[i];
        return acc;
    endfunction

    function automatic map_result_t predict_command(logic [1:0] cmd, logic [31:0] fb,
                                                    logic [11:0] rs, logic [12:0] rc);
        map_result_t r;
        longint unsigned acc;
        int hit;
        int unsigned p;
        int unsigned s;
        int unsigned nxt;
        int unsigned last;
        int unsigned b;
        bit done;
        r = '{ST_OK, '0, '0, GR_EXISTING, '0};
        if (cmd == CMD_MAP_READ || cmd == CMD_MAP_WRITE) begin
            acc = 0;
            hit = -1;
            p = 0;
            for (int i = 0; i < ext_cnt && i < MAX_EXTENTS_DEF; i++) begin
                if (fb < acc + ext_len[i]) begin
                    hit = i;
                    p = ext_first[i] + int'(fb - acc);
                    break;
                end
                acc += ext_len[i];
            end
            if (hit >= 0) begin
                r.phys = p[11:0];
                r.idx = hit[3:0];
            end else if (cmd == CMD_MAP_READ) begin
                r.status = ST_UNMAPPED;
            end else begin
                done = 1'b0;
                if (ext_cnt > 0 && fb == acc) begin
                    last = ext_cnt - 1;
                    nxt = ext_first[last] + ext_len[last];
                    if (!blk_taken(nxt)) begin
                        take_blk(nxt);
                        ext_len[last] = (ext_len[last] + 1) & 32'h1FFF;
                        r.phys = nxt[11:0];
                        r.idx = last[3:0];
                        r.growth = GR_EXTENDED;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    if (ext_cnt >= MAX_EXTENTS_DEF || !fit_run(1, s)) begin
                        r.status = ST_NO_SPACE;
                    end else begin
                        ext_first[ext_cnt] = s & 32'hFFF;
                        ext_len[ext_cnt] = 1;
                        r.idx = ext_cnt[3:0];
                        ext_cnt++;
                        r.phys = s[11:0];
                        r.growth = GR_NEW;
                    end
                end
            end
        end else if (cmd == CMD_ALLOC_RUN) begin
            if (fit_run(rc, s)) begin
                r.phys = s[11:0];
                allocated_runs.push_back('{s, rc});
            end else begin
                r.status = ST_NO_SPACE;
            end
        end else begin
            for (int unsigned i = 0; i < rc; i++) begin
                b = rs + i;
                if (b >= disk_lim() || !used_map[b]) begin
                    r.status = ST_BAD_FREE;
                    break;
                end
                used_map[b] = 1'b0;
                if (free_tot < BLOCKS_DEF)
                    free_tot++;
            end
        end
        r.free = free_tot[12:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
        errors++;
    endtask

    task automatic send_item(logic [1:0] cmd, logic [31:0] fb, logic [11:0] rs,
                             logic [12:0] rc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command       <= cmd;
        logical_block <= fb;
        run_start     <= rs;
        run_count     <= rc;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_command(cmd, fb, rs, rc));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[12:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ALLOC_BASE)
            alloc_base_cfg = value & 32'hFFF;
        else
            total_cfg = value & 32'h1FFF;
    endtask

    task automatic test_directed();
        run_t run;
        send_item(CMD_MAP_READ, 0, 0, 1);
        send_item(CMD_MAP_READ, 32'hFFFF_FFFF, 12'hFFF, 13'h1FFF);
        send_item(CMD_MAP_WRITE, 5, 0, 1);
        send_item(CMD_MAP_WRITE, 1, 0, 1);
        send_item(CMD_MAP_WRITE, 1, 0, 1);
        send_item(CMD_MAP_READ, 0, 0, 1);
        send_item(CMD_MAP_WRITE, 32'hFFFF_FFFF, 0, 1);
        send_item(CMD_ALLOC_RUN, 0, 0, 0);
        send_item(CMD_ALLOC_RUN, 0, 0, 4096);
        send_item(CMD_ALLOC_RUN, 0, 0, 3);
        run = allocated_runs[$];
        send_item(CMD_FREE_RUN, 0, 12'd100, 0);
        send_item(CMD_FREE_RUN, 0, run.first[11:0], run.count[12:0]);
        send_item(CMD_FREE_RUN, 0, run.first[11:0], run.count[12:0]);
        send_item(CMD_FREE_RUN, 0, 12'hFFF, 2);
        send_item(CMD_MAP_WRITE, 3, 0, 1);
        send_item(CMD_ALLOC_RUN, 0, 0, 1);
        send_item(CMD_MAP_READ, 2, 0, 1);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_DISK_BLOCKS, 1);
        send_item(CMD_ALLOC_RUN, 0, 0, 1);
        send_item(CMD_FREE_RUN, 0, 12'd1, 1);
        write_reg(CFG_DISK_BLOCKS, 4096);
        write_reg(CFG_ALLOC_BASE, 4095);
        send_item(CMD_ALLOC_RUN, 0, 0, 2);
        send_item(CMD_ALLOC_RUN, 0, 0, 1);
        send_item(CMD_ALLOC_RUN, 0, 0, 1);
        write_reg(CFG_ALLOC_BASE, 0);
        write_reg(CFG_DISK_BLOCKS, 8191);
        send_item(CMD_ALLOC_RUN, 0, 0, 1);
        send_item(CMD_FREE_RUN, 0, 12'd0, 1);
        // disk ends right after the last extent: growth must give way to a new extent, or to no space if none fits
        drain();
        if (ext_cnt > 0)
            write_reg(CFG_DISK_BLOCKS, ext_first[ext_cnt-1] + ext_len[ext_cnt-1]);
        send_item(CMD_MAP_WRITE, 32'(mapped_blocks()), 0, 1);
        write_reg(CFG_DISK_BLOCKS, 4096);
        write_reg(CFG_ALLOC_BASE, 1);
    endtask

    task automatic test_random(int n);
        int r;
        longint unsigned m;
        logic [31:0] fb;
        run_t run;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            m = mapped_blocks();
            if (r < 28) begin
                if ($urandom_range(0, 9) < 6 || m == 0)
                    fb = 32'(m);
                else if ($urandom_range(0, 9) < 8)
                    fb = $urandom_range(0, int'(m) - 1);
                else
                    fb = $urandom();
                send_item(CMD_MAP_WRITE, fb, 12'($urandom()), 13'($urandom()));
            end else if (r < 50) begin
                if ($urandom_range(0, 1) && m > 0)
                    fb = $urandom_range(0, int'(m));
                else
                    fb = $urandom();
                send_item(CMD_MAP_READ, fb, 12'($urandom()), 13'($urandom()));
            end else if (r < 72) begin
                send_item(CMD_ALLOC_RUN, $urandom(), 12'($urandom()),
                          13'(($urandom_range(0, 49) == 0) ? $urandom_range(0, 8191)
                                                           : $urandom_range(1, 8)));
            end else if (allocated_runs.size() > 0 && r < 92) begin
                run = allocated_runs.pop_front();
                send_item(CMD_FREE_RUN, $urandom(), run.first[11:0],
                          13'($urandom_range(0, 3) ? run.count : run.count + 1));
            end else begin
                send_item(CMD_FREE_RUN, $urandom(), 12'($urandom()),
                          13'(($urandom_range(0, 9) == 0) ? $urandom()
                                                          : $urandom_range(0, 6)));
            end
        end
    endtask

    task automatic test_extent_full();
        repeat (MAX_EXTENTS_DEF + 2)
            send_item(CMD_MAP_WRITE, 32'hFFFF_FFF0, 0, 1);
        send_item(CMD_ALLOC_RUN, 0, 0, 1);
        send_item(CMD_MAP_WRITE, 32'(mapped_blocks()), 0, 1);
        send_item(CMD_MAP_READ, 32'(mapped_blocks()) - 1, 0, 1);
    endtask

    task automatic test_output_hold_off();
        drain();
        hold_len = 400;
        no_gaps = 1'b1;
        repeat (12)
            send_item(CMD_MAP_READ, $urandom_range(0, 40), 0, 1);
        no_gaps = 1'b0;
    endtask

    // result stall: random gaps, or a long hold-off when asked
    initial begin
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_len > 0) begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        map_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", status, 0);
            end else begin
                e = pending_results.pop_front();
                if (status !== e.status)
                    report_mismatch("status", status, e.status);
                if (mapped_block !== e.phys)
                    report_mismatch("mapped_block", mapped_block, e.phys);
                if (extent_index !== e.idx)
                    report_mismatch("extent_index", extent_index, e.idx);
                if (growth !== e.growth)
                    report_mismatch("growth", growth, e.growth);
                if (free_count !== e.free)
                    report_mismatch("free_count", free_count, e.free);
            end
        end
    end

    initial begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        errors = 0;
        no_gaps = 1'b0;
        hold_len = 0;
        ext_cnt = 0;
        free_tot = BLOCKS_DEF;
        alloc_base_cfg = 1;
        total_cfg = 4096;
        foreach (used_map[i])
            used_map[i] = 1'b0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        command       <= CMD_MAP_READ;
        logical_block <= '0;
        run_start     <= '0;
        run_count     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_random(420);
        test_output_hold_off();
        write_reg(CFG_ALLOC_BASE, $urandom_range(0, 100));
        write_reg(CFG_DISK_BLOCKS, 3000);
        test_random(420);
        test_extent_full();
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: extent_block_map_allocator_top.f
+incdir+rtl
rtl/ebma_pkg.sv
rtl/ebma_ram.sv
rtl/ebma_front.sv
rtl/ebma_back.sv
rtl/extent_block_map_allocator_top.sv
tb/tb.sv
